// File: rtl/pidrt_pkg.sv
package pidrt_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int GAIN_W     = 24;
  localparam int MUL_A_W    = 25;
  localparam int MUL_B_W    = 33;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int CHUNK_W    = 32;
  localparam int DRIVE_W    = 32;
  localparam int OUT_SHIFT  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam int SH_KP    = 24;
  localparam int SH_KD_LO = 16;
  localparam int SH_KI_HI = 32;
  localparam int SH_KD_HI = 48;

  localparam logic [CFG_ADDR_W-1:0] REG_MODE  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KP    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KI    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_KD    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_HPER  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_IPER  = 3'd5;

  localparam logic [1:0] MODE_P   = 2'd0;
  localparam logic [1:0] MODE_PI  = 2'd1;
  localparam logic [1:0] MODE_PID = 2'd2;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_MP   = 10'b00_0000_0010,
    S_AREA = 10'b00_0000_0100,
    S_INT  = 10'b00_0000_1000,
    S_KI0  = 10'b00_0001_0000,
    S_KI1  = 10'b00_0010_0000,
    S_KD0  = 10'b00_0100_0000,
    S_KD1  = 10'b00_1000_0000,
    S_KD2  = 10'b01_0000_0000,
    S_FIN  = 10'b10_0000_0000
  } state_e;

endpackage

// File: rtl/pid_regulator_trapezoidal_core.sv
// A single 25x33 multiplier forms every product in turn under the step sequencer, which
// runs MP and AREA, then INT, KI0, KI1 and KD0 in PI and PID modes, then KD1 and KD2 in
// PID mode, then FIN until the output register is free. Input is taken only in IDLE.
// A finished result waits in the output register while the next item is accepted.
// Reset (rst_ni low, asynchronous): mode = PID, gains and periods zero, integral and
// previous error zero, output empty.
module pid_regulator_trapezoidal_core #(
  parameter int ERROR_WIDTH = 16,
  parameter int ACC_WIDTH   = 56
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [ERROR_WIDTH-1:0] error
  input  logic [((ERROR_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // [31:0] drive, [32] saturated, [39:33] zero
  output logic [pidrt_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  input  logic                                   cfg_we_i,
  input  logic [pidrt_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [pidrt_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  localparam int PW        = pidrt_pkg::PROD_W;
  localparam int ACC_SUM_W = ((ACC_WIDTH > PW) ? ACC_WIDTH : PW) + 1;
  localparam int KI_TERM_W = pidrt_pkg::GAIN_W + ACC_WIDTH + 1;
  localparam int KD_TERM_W = 2 * pidrt_pkg::GAIN_W + ERROR_WIDTH + 2 + pidrt_pkg::SH_KD_LO;
  localparam int TERM_W    = (KI_TERM_W > KD_TERM_W) ? KI_TERM_W : KD_TERM_W;
  localparam int SUM_W     = ((TERM_W > 80) ? TERM_W : 80) + 2;
  localparam int TOP_LSB   = pidrt_pkg::OUT_SHIFT + pidrt_pkg::DRIVE_W - 1;

  pidrt_pkg::state_e state_q, state_d;

  logic [1:0]                          mode_q;
  logic signed [pidrt_pkg::GAIN_W-1:0] kp_q, ki_q, kd_q;
  logic [pidrt_pkg::GAIN_W-1:0]        hper_q, iper_q;

  logic signed [ERROR_WIDTH-1:0]       e_q, prev_q;
  logic signed [ACC_WIDTH-1:0]         acc_q;
  logic signed [PW-1:0]                prod_q, d_q;
  logic signed [SUM_W-1:0]             sum_q;
  logic                                clip_q;

  logic                                out_valid_q;
  logic [pidrt_pkg::DRIVE_W-1:0]       drive_q;
  logic                                sat_q;

  logic signed [pidrt_pkg::MUL_A_W-1:0] mul_a;
  logic signed [pidrt_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0]                 mul_p;
  logic signed [pidrt_pkg::MUL_B_W-1:0] e_sum, e_dif;
  logic signed [63:0]                   acc_ext, d_ext;
  logic signed [SUM_W-1:0]              addend;
  logic signed [ACC_SUM_W-1:0]          acc_wide;
  logic [ACC_SUM_W-ACC_WIDTH:0]         acc_hi;
  logic                                 acc_ok;
  logic signed [ACC_WIDTH-1:0]          acc_sat;
  logic [SUM_W-TOP_LSB-1:0]             sum_hi;
  logic                                 drv_ok;
  logic [pidrt_pkg::DRIVE_W-1:0]        drv_sat;
  logic                                 in_acc, out_free;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == pidrt_pkg::S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(pidrt_pkg::OUT_TDATA_W - pidrt_pkg::DRIVE_W - 1){1'b0}},
                          sat_q, drive_q};

  assign e_sum   = pidrt_pkg::MUL_B_W'(e_q) + pidrt_pkg::MUL_B_W'(prev_q);
  assign e_dif   = pidrt_pkg::MUL_B_W'(e_q) - pidrt_pkg::MUL_B_W'(prev_q);
  assign acc_ext = 64'(acc_q);
  assign d_ext   = 64'(d_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      pidrt_pkg::S_MP: begin
        mul_a = {kp_q[pidrt_pkg::GAIN_W-1], kp_q};
        mul_b = pidrt_pkg::MUL_B_W'(e_q);
      end
      pidrt_pkg::S_AREA: begin
        mul_a = {1'b0, hper_q};
        mul_b = e_sum;
      end
      pidrt_pkg::S_INT: begin
        mul_a = {1'b0, iper_q};
        mul_b = e_dif;
      end
      pidrt_pkg::S_KI0: begin
        mul_a = {ki_q[pidrt_pkg::GAIN_W-1], ki_q};
        mul_b = {1'b0, acc_ext[pidrt_pkg::CHUNK_W-1:0]};
      end
      pidrt_pkg::S_KI1: begin
        mul_a = {ki_q[pidrt_pkg::GAIN_W-1], ki_q};
        mul_b = {acc_ext[63], acc_ext[63:pidrt_pkg::CHUNK_W]};
      end
      pidrt_pkg::S_KD0: begin
        mul_a = {kd_q[pidrt_pkg::GAIN_W-1], kd_q};
        mul_b = {1'b0, d_ext[pidrt_pkg::CHUNK_W-1:0]};
      end
      pidrt_pkg::S_KD1: begin
        mul_a = {kd_q[pidrt_pkg::GAIN_W-1], kd_q};
        mul_b = {d_ext[63], d_ext[63:pidrt_pkg::CHUNK_W]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    case (state_q)
      pidrt_pkg::S_AREA: addend = SUM_W'(prod_q) <<< pidrt_pkg::SH_KP;
      pidrt_pkg::S_KI1:  addend = SUM_W'(prod_q);
      pidrt_pkg::S_KD0:  addend = SUM_W'(prod_q) <<< pidrt_pkg::SH_KI_HI;
      pidrt_pkg::S_KD1:  addend = SUM_W'(prod_q) <<< pidrt_pkg::SH_KD_LO;
      pidrt_pkg::S_KD2:  addend = SUM_W'(prod_q) <<< pidrt_pkg::SH_KD_HI;
      default:           addend = '0;
    endcase
  end

  assign acc_wide = ACC_SUM_W'(acc_q) + ACC_SUM_W'(prod_q);
  assign acc_hi   = acc_wide[ACC_SUM_W-1:ACC_WIDTH-1];
  assign acc_ok   = (&acc_hi) || !(|acc_hi);
  assign acc_sat  = acc_ok ? acc_wide[ACC_WIDTH-1:0] :
                    (acc_wide[ACC_SUM_W-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                           : {1'b0, {(ACC_WIDTH-1){1'b1}}});

  assign sum_hi  = sum_q[SUM_W-1:TOP_LSB];
  assign drv_ok  = (&sum_hi) || !(|sum_hi);
  assign drv_sat = drv_ok ? sum_q[TOP_LSB:pidrt_pkg::OUT_SHIFT] :
                   (sum_q[SUM_W-1] ? {1'b1, {(pidrt_pkg::DRIVE_W-1){1'b0}}}
                                   : {1'b0, {(pidrt_pkg::DRIVE_W-1){1'b1}}});

  always_comb begin
    state_d = state_q;
    case (state_q)
      pidrt_pkg::S_IDLE: if (in_acc) state_d = pidrt_pkg::S_MP;
      pidrt_pkg::S_MP:   state_d = pidrt_pkg::S_AREA;
      pidrt_pkg::S_AREA: begin
        state_d = (mode_q == pidrt_pkg::MODE_P) ? pidrt_pkg::S_FIN : pidrt_pkg::S_INT;
      end
      pidrt_pkg::S_INT:  state_d = pidrt_pkg::S_KI0;
      pidrt_pkg::S_KI0:  state_d = pidrt_pkg::S_KI1;
      pidrt_pkg::S_KI1:  state_d = pidrt_pkg::S_KD0;
      pidrt_pkg::S_KD0: begin
        state_d = (mode_q == pidrt_pkg::MODE_PI) ? pidrt_pkg::S_FIN : pidrt_pkg::S_KD1;
      end
      pidrt_pkg::S_KD1:  state_d = pidrt_pkg::S_KD2;
      pidrt_pkg::S_KD2:  state_d = pidrt_pkg::S_FIN;
      pidrt_pkg::S_FIN:  if (out_free) state_d = pidrt_pkg::S_IDLE;
      default:           state_d = pidrt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pidrt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= pidrt_pkg::MODE_PID;
      kp_q   <= '0;
      ki_q   <= '0;
      kd_q   <= '0;
      hper_q <= '0;
      iper_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        pidrt_pkg::REG_MODE: mode_q <= cfg_wdata_i[1:0];
        pidrt_pkg::REG_KP:   kp_q   <= cfg_wdata_i;
        pidrt_pkg::REG_KI:   ki_q   <= cfg_wdata_i;
        pidrt_pkg::REG_KD:   kd_q   <= cfg_wdata_i;
        pidrt_pkg::REG_HPER: hper_q <= cfg_wdata_i;
        pidrt_pkg::REG_IPER: iper_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      prev_q <= '0;
      clip_q <= 1'b0;
    end else begin
      case (state_q)
        pidrt_pkg::S_IDLE: if (in_acc) clip_q <= 1'b0;
        pidrt_pkg::S_INT: begin
          acc_q  <= acc_sat;
          prev_q <= e_q;
          if (!acc_ok) clip_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (in_acc) begin
      e_q   <= s_axis_tdata[ERROR_WIDTH-1:0];
      sum_q <= '0;
    end else begin
      sum_q <= sum_q + addend;
    end
    if (state_q == pidrt_pkg::S_KI0) d_q <= prod_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == pidrt_pkg::S_FIN && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == pidrt_pkg::S_FIN && out_free) begin
      drive_q <= drv_sat;
      sat_q   <= clip_q || !drv_ok;
    end
  end

endmodule

// File: rtl/pidrt_checker.sv
module pidrt_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_tvalid_i,
  input logic                              s_tready_i,
  input logic                              m_tvalid_i,
  input logic                              m_tready_i,
  input logic [pidrt_pkg::OUT_TDATA_W-1:0] m_tdata_i
);

  // hold a pending result until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("result dropped or changed while stalled");

  // drop ready after an input transaction
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !s_tready_i)
    else $error("ready stayed high after input transaction");

  // no new result in the cycle after an input transaction
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !$rose(m_tvalid_i))
    else $error("result appeared too early");

  // keep pad bits of the result clear
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> m_tdata_i[pidrt_pkg::OUT_TDATA_W-1:pidrt_pkg::DRIVE_W+1] == '0)
    else $error("result pad bits not zero");

endmodule

bind pid_regulator_trapezoidal_core pidrt_checker u_pidrt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid),
  .s_tready_i (s_axis_tready),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata)
);
